// ----- rtl/tsr_pkg.sv -----
// Package for the TCP segment reorder unit: beat types, action codes, entry type.
// No dependencies.
`default_nettype none
package tsr_pkg;

  localparam logic [2:0] ACT_DIRECT     = 3'd0;
  localparam logic [2:0] ACT_FROM_QUEUE = 3'd1;
  localparam logic [2:0] ACT_QUEUED     = 3'd2;
  localparam logic [2:0] ACT_FULL       = 3'd3;
  localparam logic [2:0] ACT_OLD        = 3'd4;
  localparam logic [2:0] ACT_STALE      = 3'd5;
  localparam logic [2:0] ACT_SYN        = 3'd6;
  localparam logic [2:0] ACT_RESET      = 3'd7;

  typedef struct packed {
    logic [31:0] seq_number;
    logic [15:0] payload_length;
    logic [7:0]  buffer_tag;
    logic        syn_flag;
    logic        rst_flag;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  out_tag;
    logic [31:0] out_seq;
    logic [15:0] out_length;
    logic        last;
  } out_beat_t;

  typedef struct packed {
    logic [31:0] seq;
    logic [15:0] len;
    logic [7:0]  tag;
  } entry_t;

  // control broadcast from the sequencer to every cell
  typedef struct packed {
    logic   ins;      // insert new entry in sorted position
    logic   pop;      // shift every entry toward the head
    logic   clr;      // drop all entries
    entry_t new_ent;
  } cell_ctl_t;

endpackage
`default_nettype wire

// ----- rtl/tsr_cell.sv -----
// One queue slot of the sorted pending chain.
// Depends on tsr_pkg.
`default_nettype none
module tsr_cell (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire tsr_pkg::cell_ctl_t   ctl,
  input  wire logic                 prev_valid,
  input  wire logic                 prev_gt,     // previous cell holds seq > new
  input  wire tsr_pkg::entry_t      prev_ent,
  input  wire logic                 next_valid,
  input  wire tsr_pkg::entry_t      next_ent,
  output logic                      valid,
  output logic                      gt,
  output tsr_pkg::entry_t           ent
);
  import tsr_pkg::*;

  logic   valid_r, valid_nxt;
  entry_t ent_r, ent_nxt;

  assign valid = valid_r;
  assign ent   = ent_r;
  assign gt    = valid_r && (ent_r.seq > ctl.new_ent.seq);

  always_comb begin
    valid_nxt = valid_r;
    ent_nxt   = ent_r;
    if (ctl.clr) begin
      valid_nxt = 1'b0;
    end else if (ctl.pop) begin
      valid_nxt = next_valid;
      ent_nxt   = next_ent;
    end else if (ctl.ins) begin
      if (gt && prev_gt) begin
        ent_nxt = prev_ent;
      end else if (gt || (!valid_r && prev_valid && !prev_gt)) begin
        ent_nxt   = ctl.new_ent;
        valid_nxt = 1'b1;
      end else if (!valid_r && prev_gt) begin
        ent_nxt   = prev_ent;
        valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    ent_r <= ent_nxt;
  end

endmodule
`default_nettype wire

// ----- rtl/tcp_segment_reorder_unit.sv -----
// Top level of the TCP segment reorder unit: sequencer plus chain of queue cells.
// Depends on tsr_pkg and tsr_cell.
// The first result appears in the cycle after start; drain gives one result a cycle.
// Segments do not overlap: start is taken only when idle, and busy is high in the drain and gap states.
// Reset: expected number, syn state and queue cleared; queue_limit returns to 16.
// Results are strobed for one cycle; the receiver cannot stall.
`default_nettype none
module tcp_segment_reorder_unit #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire tsr_pkg::in_beat_t   in_beat,
  output logic                     out_valid,
  output tsr_pkg::out_beat_t       out_beat,
  input  wire logic                cfg_we,
  input  wire logic [4:0]          cfg_wdata
);
  import tsr_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_DRAIN = 2'd1;
  localparam logic [1:0] ST_GAP   = 2'd2;

  logic [1:0]    st_r, st_nxt;
  logic [4:0]    lim_r;
  logic [31:0]   exp_r, exp_nxt;
  logic          syn_r, syn_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          ov_r, ov_nxt;
  out_beat_t     ob_r, ob_nxt;
  cell_ctl_t     ctl;

  logic   v   [QUEUE_DEPTH+1];
  logic   g   [QUEUE_DEPTH+1];
  entry_t e   [QUEUE_DEPTH+1];
  logic   nv  [QUEUE_DEPTH];
  entry_t ne  [QUEUE_DEPTH];

  assign v[0] = 1'b1;
  assign g[0] = 1'b0;
  assign e[0] = ctl.new_ent;

  genvar k;
  generate
    for (k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
      if (k == QUEUE_DEPTH - 1) begin : g_end
        assign nv[k] = 1'b0;
        assign ne[k] = e[k+1];
      end else begin : g_mid
        assign nv[k] = v[k+2];
        assign ne[k] = e[k+2];
      end
      tsr_cell u_cell (
        .clk(clk), .rst_n(rst_n), .ctl(ctl),
        .prev_valid(v[k]), .prev_gt(g[k]), .prev_ent(e[k]),
        .next_valid(nv[k]), .next_ent(ne[k]),
        .valid(v[k+1]), .gt(g[k+1]), .ent(e[k+1])
      );
    end
  endgenerate

  logic [CW-1:0] eff_lim;
  logic [31:0]   base;
  entry_t        hd;
  logic [31:0]   hd_end;

  assign hd     = e[1];
  assign hd_end = exp_r + {16'd0, hd.len};
  assign busy   = (st_r != ST_IDLE);
  assign out_valid = ov_r;
  assign out_beat  = ob_r;

  always_comb begin
    if ({{(32-5){1'b0}}, lim_r} > QUEUE_DEPTH) eff_lim = CW'(QUEUE_DEPTH);
    else eff_lim = CW'(lim_r);
    base = (exp_r == 32'd0 && !syn_r) ? in_beat.seq_number : exp_r;
  end

  always_comb begin
    st_nxt  = st_r;
    exp_nxt = exp_r;
    syn_nxt = syn_r;
    cnt_nxt = cnt_r;
    ov_nxt  = 1'b0;
    ob_nxt  = ob_r;
    ctl     = '0;
    ctl.new_ent = '{seq: in_beat.seq_number, len: in_beat.payload_length,
                    tag: in_beat.buffer_tag};
    case (st_r)
      ST_IDLE: begin
        if (start && in_beat.payload_length != 16'd0) begin
          ov_nxt = 1'b1;
          ob_nxt = '{action: ACT_OLD, out_tag: in_beat.buffer_tag,
                     out_seq: in_beat.seq_number,
                     out_length: in_beat.payload_length, last: 1'b1};
          st_nxt = ST_GAP;
          if (in_beat.syn_flag) begin
            syn_nxt = 1'b1;
            exp_nxt = in_beat.seq_number + 32'd1;
            ob_nxt.action = ACT_SYN;
            ob_nxt.out_length = 16'd0;
          end else if (in_beat.rst_flag) begin
            exp_nxt = 32'd0;
            syn_nxt = 1'b0;
            cnt_nxt = '0;
            ctl.clr = 1'b1;
            ob_nxt.action = ACT_RESET;
            ob_nxt.out_length = 16'd0;
          end else if (in_beat.seq_number == base) begin
            ob_nxt.action = ACT_DIRECT;
            exp_nxt = base + {16'd0, in_beat.payload_length};
            if (cnt_r != '0 && hd.seq <= exp_nxt) begin
              ob_nxt.last = 1'b0;
              st_nxt = ST_DRAIN;
            end
          end else if (in_beat.seq_number > base) begin
            exp_nxt = base;
            if (cnt_r < eff_lim) begin
              ctl.ins = 1'b1;
              cnt_nxt = cnt_r + CW'(1);
              ob_nxt.action = ACT_QUEUED;
            end else begin
              ob_nxt.action = ACT_FULL;
            end
          end else begin
            exp_nxt = base;
          end
        end
      end
      ST_DRAIN: begin
        if (hd.seq <= exp_r) begin
          ov_nxt = 1'b1;
          ctl.pop = 1'b1;
          cnt_nxt = cnt_r - CW'(1);
          ob_nxt = '{action: ACT_STALE, out_tag: hd.tag, out_seq: hd.seq,
                     out_length: hd.len, last: 1'b0};
          if (hd.seq == exp_r) begin
            ob_nxt.action = ACT_FROM_QUEUE;
            exp_nxt = hd_end;
          end
          if (cnt_r == CW'(1) ||
              (e[2].seq > ((hd.seq == exp_r) ? hd_end : exp_r))) begin
            ob_nxt.last = 1'b1;
            st_nxt = ST_GAP;
          end
        end else begin
          st_nxt = ST_IDLE;
        end
      end
      ST_GAP: st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_IDLE;
      lim_r <= 5'd16;
      exp_r <= '0;
      syn_r <= 1'b0;
      cnt_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      if (cfg_we) lim_r <= cfg_wdata;
      exp_r <= exp_nxt;
      syn_r <= syn_nxt;
      cnt_r <= cnt_nxt;
      ov_r  <= ov_nxt;
    end
    ob_r <= ob_nxt;
  end

endmodule
`default_nettype wire
